[sv/rme_pkg.sv]
// shared constants, codes and controller/datapath interface types for the modular exponentiator
package rme_pkg;

   localparam int MODULUS_BITS_DEF = 31;
   localparam int CFG_W            = 31;
   localparam int VALUE_W          = 32;
   localparam int CODE_W           = 33;
   localparam int MAG_W            = 33;
   localparam int CHAR_OFFSET      = 96;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENC_EXP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEC_EXP = 2'd2;

   localparam logic OP_ENCRYPT = 1'b0;

   localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd3233;
   localparam logic [CFG_W-1:0] ENC_EXP_RESET = 31'd17;
   localparam logic [CFG_W-1:0] DEC_EXP_RESET = 31'd2753;

   typedef enum logic [1:0] {
      RES_ONE,
      RES_ZERO,
      RES_POW
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        red_load;
      logic        red_from_prod;
      logic        red_step;
      logic        mul_en;
      logic        mul_from_acc;
      logic        sq_wr;
      logic        acc_wr;
      logic        exp_shift;
      logic        res_wr;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic mod_small;
      logic exp_lsb;
      logic exp_next_lsb;
      logic exp_last;
      logic red_last;
   } status_type;

endpackage

[sv/rme_csr.sv]
// configuration registers: modulus and the two exponents
module rme_csr #(
   parameter int MODULUS_BITS = rme_pkg::MODULUS_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rme_pkg::CFG_W-1:0]      csr_wdata,
   output logic [MODULUS_BITS-1:0]        modulus,
   output logic [rme_pkg::CFG_W-1:0]      enc_exp,
   output logic [rme_pkg::CFG_W-1:0]      dec_exp
);
   import rme_pkg::*;

   logic [MODULUS_BITS-1:0] modulus_ff;
   logic [CFG_W-1:0]        enc_exp_ff;
   logic [CFG_W-1:0]        dec_exp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[MODULUS_BITS-1:0];
         enc_exp_ff <= ENC_EXP_RESET;
         dec_exp_ff <= DEC_EXP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata[MODULUS_BITS-1:0];
            CSR_ENC_EXP: enc_exp_ff <= csr_wdata;
            CSR_DEC_EXP: dec_exp_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign modulus = modulus_ff;
   assign enc_exp = enc_exp_ff;
   assign dec_exp = dec_exp_ff;

endmodule

[sv/rme_dp.sv]
// datapath: operand setup, multiplier, bit-serial remainder unit and result formatting
module rme_dp #(
   parameter int MODULUS_BITS = rme_pkg::MODULUS_BITS_DEF
) (
   input  logic                                clock,
   input  rme_pkg::cmd_type                    cmd,
   output rme_pkg::status_type                 status,
   input  logic                                req_opcode,
   input  logic signed [rme_pkg::VALUE_W-1:0]  req_value,
   input  logic [MODULUS_BITS-1:0]             modulus,
   input  logic [rme_pkg::CFG_W-1:0]           enc_exp,
   input  logic [rme_pkg::CFG_W-1:0]           dec_exp,
   output logic signed [rme_pkg::VALUE_W-1:0]  rsp_residue,
   output logic signed [rme_pkg::CODE_W-1:0]   rsp_shifted_code
);
   import rme_pkg::*;

   localparam int M      = MODULUS_BITS;
   localparam int PROD_W = 2 * M;
   localparam int RED_W  = (PROD_W > MAG_W) ? PROD_W : MAG_W;
   localparam int CNT_W  = $clog2(RED_W + 1);

   // item setup
   logic signed [MAG_W-1:0] offset;
   logic signed [MAG_W-1:0] sval;
   logic [MAG_W-1:0]        mag_in;
   logic [CFG_W-1:0]        exp_in;

   logic [MAG_W-1:0]   mag_ff;
   logic               neg_ff;
   logic               odd_ff;
   logic [CFG_W-1:0]   exp_ff;
   logic [M-1:0]       acc_ff;
   logic [M-1:0]       sq_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [M-1:0]       mul_a;
   logic [RED_W-1:0]   div_ff;
   logic [M-1:0]       rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [M:0]         trial;
   logic [M:0]         mod_ext;
   logic [M-1:0]       rem_in;

   logic [M-1:0]                res_mag;
   logic                        res_neg;
   logic signed [VALUE_W-1:0]   res_in;
   logic signed [VALUE_W-1:0]   res_ff;
   logic signed [CODE_W-1:0]    code_ff;

   always_comb begin
      offset = (req_opcode == OP_ENCRYPT) ? MAG_W'(CHAR_OFFSET) : '0;
      sval   = MAG_W'(req_value) - offset;
      mag_in = sval[MAG_W-1] ? MAG_W'(-sval) : MAG_W'(sval);
      exp_in = (req_opcode == OP_ENCRYPT) ? enc_exp : dec_exp;
   end

   assign mul_a   = cmd.mul_from_acc ? acc_ff : sq_ff;
   assign prod_in = mul_a * sq_ff;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      mod_ext = {1'b0, modulus};
      trial   = {rem_ff, div_ff[RED_W-1]};
      if (trial >= mod_ext) begin
         rem_in = M'(trial - mod_ext);
      end else begin
         rem_in = M'(trial);
      end
   end

   always_comb begin
      case (cmd.res_sel)
         RES_ONE:  res_mag = M'(1);
         RES_ZERO: res_mag = '0;
         RES_POW:  res_mag = rem_ff;
         default:  res_mag = '0;
      endcase
      res_neg = neg_ff && odd_ff && (res_mag != '0);
      res_in  = VALUE_W'(res_mag);
      if (res_neg) begin
         res_in = -res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= mag_in;
         neg_ff <= sval[MAG_W-1];
         odd_ff <= exp_in[0];
         exp_ff <= exp_in;
         acc_ff <= M'(1);
      end
      if (cmd.exp_shift) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.red_load) begin
         div_ff <= cmd.red_from_prod ? RED_W'(prod_ff) : RED_W'(mag_ff);
         rem_ff <= '0;
         cnt_ff <= CNT_W'(RED_W);
      end else if (cmd.red_step) begin
         div_ff <= div_ff << 1;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.sq_wr) begin
         sq_ff <= rem_ff;
      end
      if (cmd.acc_wr) begin
         acc_ff <= rem_ff;
      end
      if (cmd.res_wr) begin
         res_ff  <= res_in;
         code_ff <= CODE_W'(res_in) + CODE_W'(CHAR_OFFSET);
      end
   end

   always_comb begin
      status.exp_zero     = (exp_ff == '0);
      status.mod_small    = (modulus < M'(2));
      status.exp_lsb      = exp_ff[0];
      status.exp_next_lsb = exp_ff[1];
      status.exp_last     = ((exp_ff >> 1) == '0);
      status.red_last     = (cnt_ff == CNT_W'(1));
   end

   assign rsp_residue      = res_ff;
   assign rsp_shifted_code = code_ff;

endmodule

[sv/rme_ctrl.sv]
// controller: sequences base reduction, multiply and square steps per exponent bit
module rme_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  rme_pkg::status_type  status,
   output rme_pkg::cmd_type     cmd
);
   import rme_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_BASE_RED,
      S_SETUP,
      S_MUL_ACC,
      S_LOAD_ACC,
      S_RED_ACC,
      S_WR_ACC,
      S_MUL_SQ,
      S_LOAD_SQ,
      S_RED_SQ,
      S_WR_SQ
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      valid_ff;
   logic      valid_in;

   always_comb begin
      cmd         = '0;
      cmd.res_sel = RES_POW;
      state_in    = state_ff;
      valid_in    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.exp_zero) begin
               cmd.res_wr  = 1'b1;
               cmd.res_sel = RES_ONE;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end else if (status.mod_small) begin
               cmd.res_wr  = 1'b1;
               cmd.res_sel = RES_ZERO;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.red_load = 1'b1;
               state_in     = S_BASE_RED;
            end
         end
         S_BASE_RED: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.sq_wr = 1'b1;
            state_in  = status.exp_lsb ? S_MUL_ACC : S_MUL_SQ;
         end
         S_MUL_ACC: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_from_acc = 1'b1;
            state_in         = S_LOAD_ACC;
         end
         S_LOAD_ACC: begin
            cmd.red_load      = 1'b1;
            cmd.red_from_prod = 1'b1;
            state_in          = S_RED_ACC;
         end
         S_RED_ACC: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = S_WR_ACC;
            end
         end
         S_WR_ACC: begin
            cmd.acc_wr = 1'b1;
            // last set bit of the exponent: the remainder is the final power
            if (status.exp_last) begin
               cmd.res_wr = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_MUL_SQ;
            end
         end
         S_MUL_SQ: begin
            cmd.mul_en = 1'b1;
            state_in   = S_LOAD_SQ;
         end
         S_LOAD_SQ: begin
            cmd.red_load      = 1'b1;
            cmd.red_from_prod = 1'b1;
            state_in          = S_RED_SQ;
         end
         S_RED_SQ: begin
            cmd.red_step = 1'b1;
            if (status.red_last) begin
               state_in = S_WR_SQ;
            end
         end
         S_WR_SQ: begin
            cmd.sq_wr     = 1'b1;
            cmd.exp_shift = 1'b1;
            state_in      = status.exp_next_lsb ? S_MUL_ACC : S_MUL_SQ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

[sv/rsa_modular_exponentiation.sv]
// top level of the textbook rsa modular exponentiator
//
// A transaction starts at a clock edge with start high and busy low; req_opcode
// selects encrypt (value minus 96, public exponent) or decrypt (value as is,
// private exponent). busy stays high until the result is out. The result is
// shown for exactly one cycle with rsp_valid high; it cannot be held off.
// Modulus and exponents are written through the csr_ channel (always ready);
// the user must write them only while the block is idle, which the block
// itself does not enforce; index 0 modulus, 1 encrypt and 2 decrypt exponent.
// Each modular product comes from one registered multiply and a remainder unit
// that retires one dividend bit per cycle over R = max(2*MODULUS_BITS, 33)
// bits; a multiply or square steps through its multiply, load, reduce and
// write states, and the base is reduced once before the first of them.
// A zero exponent or a modulus below two gives its result from the check state.
// One transaction at a time; a new start is taken in the cycle the result shows.
// Reset returns the controller to idle and the registers to 3233, 17 and 2753.
module rsa_modular_exponentiation #(
   parameter int MODULUS_BITS = rme_pkg::MODULUS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic signed [rme_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [rme_pkg::VALUE_W-1:0]  rsp_residue,
   output logic signed [rme_pkg::CODE_W-1:0]   rsp_shifted_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rme_pkg::CFG_W-1:0]           csr_wdata
);
   import rme_pkg::*;

   logic [MODULUS_BITS-1:0] modulus;
   logic [CFG_W-1:0]        enc_exp;
   logic [CFG_W-1:0]        dec_exp;
   cmd_type                 cmd;
   status_type              status;

   rme_csr #(
      .MODULUS_BITS(MODULUS_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .modulus   (modulus),
      .enc_exp   (enc_exp),
      .dec_exp   (dec_exp)
   );

   rme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   rme_dp #(
      .MODULUS_BITS(MODULUS_BITS)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .modulus          (modulus),
      .enc_exp          (enc_exp),
      .dec_exp          (dec_exp),
      .rsp_residue      (rsp_residue),
      .rsp_shifted_code (rsp_shifted_code)
   );

endmodule

[sim/rsa_modular_exponentiation_tb.sv]
// self-checking testbench for the rsa modular exponentiator: directed corners, random keys and values
module rsa_modular_exponentiation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rme_pkg::*;

   localparam logic OP_DECRYPT = ~OP_ENCRYPT;
   // sized for the longest transaction, a 31-bit all-ones exponent
   localparam int DRAIN_CYCLES = 4100;
   localparam int RANDOM_SETS  = 12;
   localparam int SET_ITEMS    = 155;

   typedef struct {
      bit                         is_csr;
      logic                       opcode;
      logic signed [VALUE_W-1:0]  value;
      logic [CSR_IDX_W-1:0]       index;
      logic [CFG_W-1:0]           wdata;
   } job_type;

   typedef struct {
      logic signed [VALUE_W-1:0] residue;
      logic signed [CODE_W-1:0]  shifted_code;
   } power_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_opcode = 1'b0;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic signed [VALUE_W-1:0]  rsp_residue;
   logic signed [CODE_W-1:0]   rsp_shifted_code;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CFG_W-1:0]           csr_wdata = '0;

   job_type          requests[$];
   power_result_type pending_powers[$];

   logic [CFG_W-1:0] cur_modulus = MODULUS_RESET;
   logic [CFG_W-1:0] cur_enc_exp = ENC_EXP_RESET;
   logic [CFG_W-1:0] cur_dec_exp = DEC_EXP_RESET;

   int total_items   = 0;
   int items_sent    = 0;
   int csr_writes    = 0;
   int key_settings  = 0;
   int results_seen  = 0;
   int errors        = 0;

   rsa_modular_exponentiation DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_residue      (rsp_residue),
      .rsp_shifted_code (rsp_shifted_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // signed power with truncating remainder: sign follows base only for odd exponents
   function automatic power_result_type predict_power(logic op,
                                                      logic signed [VALUE_W-1:0] val);
      longint           base;
      longint unsigned  e;
      longint unsigned  m;
      longint unsigned  magn;
      longint unsigned  acc;
      longint unsigned  sq;
      longint           r;
      longint           code;
      bit               odd;
      power_result_type res;
      base = longint'(val);
      if (op == OP_ENCRYPT) begin
         base = base - CHAR_OFFSET;
         e = 64'(cur_enc_exp);
      end else begin
         e = 64'(cur_dec_exp);
      end
      m = 64'(cur_modulus);
      magn = (base < 0) ? -base : base;
      odd = e[0];
      if (e == 0) begin
         r = 1;
      end else if (m < 2) begin
         r = 0;
      end else begin
         acc = 1;
         sq = magn % m;
         while (e != 0) begin
            if (e[0])
               acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e = e >> 1;
         end
         r = acc;
         if (base < 0 && odd && acc != 0)
            r = -r;
      end
      code = r + CHAR_OFFSET;
      res.residue = r[VALUE_W-1:0];
      res.shifted_code = code[CODE_W-1:0];
      return res;
   endfunction

   task automatic add_item(input logic op, input logic signed [VALUE_W-1:0] val);
      job_type j;
      j = '{default: '0};
      j.opcode = op;
      j.value = val;
      requests.push_back(j);
      total_items++;
   endtask

   task automatic set_regs(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] e,
                           input logic [CFG_W-1:0] d);
      job_type j;
      j = '{default: '0};
      j.is_csr = 1'b1;
      j.index = CSR_DEC_EXP;
      j.wdata = d;
      requests.push_back(j);
      j.index = CSR_MODULUS;
      j.wdata = m;
      requests.push_back(j);
      j.index = CSR_ENC_EXP;
      j.wdata = e;
      requests.push_back(j);
      key_settings++;
   endtask

   // driver: retire the transaction taken at this edge, then present the next one
   always @(posedge clock) begin : driver
      job_type head;
      logic    nxt_start;
      logic    nxt_csr;
      int      idle_pct;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         nxt_start = 1'b0;
         nxt_csr = 1'b0;
         if (start && !busy) begin
            head = requests.pop_front();
            pending_powers.push_back(predict_power(head.opcode, head.value));
            items_sent++;
         end else if (csr_valid && csr_ready) begin
            head = requests.pop_front();
            case (head.index)
               CSR_MODULUS: cur_modulus = head.wdata;
               CSR_ENC_EXP: cur_enc_exp = head.wdata;
               CSR_DEC_EXP: cur_dec_exp = head.wdata;
               default: ;
            endcase
            csr_writes++;
         end
         if (items_sent < total_items / 3)
            idle_pct = 11;
         else if (items_sent < 2 * total_items / 3)
            idle_pct = 65;
         else
            idle_pct = 0;
         if (requests.size() != 0) begin
            head = requests[0];
            if (head.is_csr) begin
               // key changes only with nothing in flight
               if (pending_powers.size() == 0) begin
                  nxt_csr = 1'b1;
                  csr_index <= head.index;
                  csr_wdata <= head.wdata;
               end
            end else if ((start && busy) || $urandom_range(0, 99) >= idle_pct) begin
               nxt_start = 1'b1;
               req_opcode <= head.opcode;
               req_value <= head.value;
            end
         end
         start <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   always @(posedge clock) begin : monitor
      power_result_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_powers.size() == 0) begin
            $display("%0t unexpected result residue %0d shifted_code %0d",
                     $time, rsp_residue, rsp_shifted_code);
            errors++;
         end else begin
            want = pending_powers.pop_front();
            if (rsp_residue !== want.residue) begin
               $display("%0t residue mismatch expected %0d actual %0d",
                        $time, want.residue, rsp_residue);
               errors++;
            end
            if (rsp_shifted_code !== want.shifted_code) begin
               $display("%0t shifted_code mismatch expected %0d actual %0d",
                        $time, want.shifted_code, rsp_shifted_code);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0]          m;
      logic [CFG_W-1:0]          ee;
      logic [CFG_W-1:0]          de;
      logic                      op;
      logic signed [VALUE_W-1:0] v;
      int                        pick;

      // reset keys: base zero, plus and minus one, extremes of the value field
      add_item(OP_ENCRYPT, 32'sd96);
      add_item(OP_ENCRYPT, 32'sd97);
      add_item(OP_ENCRYPT, 32'sd95);
      add_item(OP_ENCRYPT, 32'sd0);
      add_item(OP_ENCRYPT, 32'sd255);
      add_item(OP_ENCRYPT, 32'h7FFF_FFFF);
      add_item(OP_ENCRYPT, 32'h8000_0000);
      add_item(OP_DECRYPT, 32'sd0);
      add_item(OP_DECRYPT, 32'sd1);
      add_item(OP_DECRYPT, -32'sd1);
      add_item(OP_DECRYPT, 32'sd3232);
      add_item(OP_DECRYPT, 32'sd3233);
      add_item(OP_DECRYPT, -32'sd3234);
      add_item(OP_DECRYPT, 32'h7FFF_FFFF);
      add_item(OP_DECRYPT, 32'h8000_0000);
      // modulus of one, zero exponent wins over it
      set_regs(31'd1, 31'd5, 31'd0);
      add_item(OP_ENCRYPT, 32'sd100);
      add_item(OP_DECRYPT, -32'sd7);
      // modulus of zero
      set_regs(31'd0, 31'd0, 31'd3);
      add_item(OP_ENCRYPT, 32'sd50);
      add_item(OP_DECRYPT, -32'sd5);
      // widest modulus and exponents, odd and even
      set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFE);
      add_item(OP_ENCRYPT, 32'h8000_0000);
      add_item(OP_DECRYPT, 32'h7FFF_FFFE);
      add_item(OP_DECRYPT, -32'sd2);
      // smallest meaningful modulus
      set_regs(31'd2, 31'd1, 31'd2);
      add_item(OP_ENCRYPT, 32'sd99);
      add_item(OP_DECRYPT, -32'sd3);

      // a few transactions with full-width random keys, these are slow
      set_regs(CFG_W'($urandom_range(2, 32'h7FFF_FFFF)), CFG_W'($urandom),
               CFG_W'($urandom));
      repeat (8)
         add_item(1'($urandom_range(0, 1)), $urandom);

      // mostly short exponents to keep the run length reasonable
      for (int ph = 0; ph < RANDOM_SETS; ph++) begin
         case ($urandom_range(0, 3))
            0: m = CFG_W'($urandom_range(2, 255));
            1: m = CFG_W'($urandom_range(256, 65535));
            default: m = CFG_W'($urandom_range(2, 32'h7FFF_FFFF));
         endcase
         ee = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                          : CFG_W'($urandom_range(0, 7));
         de = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                          : CFG_W'($urandom_range(0, 7));
         set_regs(m, ee, de);
         for (int n = 0; n < SET_ITEMS; n++) begin
            op = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               v = $urandom;
            end else if (pick < 65) begin
               v = $urandom_range(0, 255);
            end else if (pick < 85) begin
               v = $urandom_range(0, 400) - 200;
            end else begin
               // near a multiple of the modulus, either sign
               v = m * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1))
                  v = -v;
            end
            add_item(op, v);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (requests.size() != 0 || pending_powers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions under %0d key settings (%0d register writes)",
               items_sent, key_settings, csr_writes);
      $display("checked %0d results, %0d mismatches", results_seen, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("timeout with %0d transactions outstanding", pending_powers.size());
      $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
sv/rme_pkg.sv
sv/rme_csr.sv
sv/rme_dp.sv
sv/rme_ctrl.sv
sv/rsa_modular_exponentiation.sv
sim/rsa_modular_exponentiation_tb.sv
